// ===== hw/rtl/rcpw_pkg.sv =====
// Package for the RC pulse width capture unit.
// Holds field widths, register indexes, reset values and window helpers.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package rcpw_pkg;

  // Payload and register widths
  localparam int PIN_W      = 8;
  localparam int STAMP_W    = 32;
  localparam int CHAN_SEL_W = 3;
  localparam int WIDTH_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Default number of watched channels
  localparam int NUM_CHANNELS_DEF = 8;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANNEL_ENABLE = 3'd0,
    REG_MIN_OFF_WIDTH  = 3'd1,
    REG_MAX_OFF_WIDTH  = 3'd2,
    REG_MIN_ON_WIDTH   = 3'd3,
    REG_MAX_ON_WIDTH   = 3'd4
  } cfg_reg_t;

  // Register reset values
  localparam logic [PIN_W-1:0]   ENABLE_RST  = 8'h0F;
  localparam logic [WIDTH_W-1:0] MIN_OFF_RST = 16'd3000;
  localparam logic [WIDTH_W-1:0] MAX_OFF_RST = 16'd25000;
  localparam logic [WIDTH_W-1:0] MIN_ON_RST  = 16'd750;
  localparam logic [WIDTH_W-1:0] MAX_ON_RST  = 16'd2250;

  // Good width after reset: channel 0 centered low, channels 1 to 3 at mid stick
  localparam logic [WIDTH_W-1:0] WIDTH_CH0_RST = 16'd1000;
  localparam logic [WIDTH_W-1:0] WIDTH_MID_RST = 16'd1500;
  localparam int                 MID_LAST_CH   = 3;

  function automatic logic [WIDTH_W-1:0] good_width_rst(input int ch);
    logic [WIDTH_W-1:0] val;
    val = '0;
    if (ch == 0) begin
      val = WIDTH_CH0_RST;
    end else if (ch <= MID_LAST_CH) begin
      val = WIDTH_MID_RST;
    end
    return val;
  endfunction

  // True when a wrapped time difference lies in [lo, hi]
  function automatic logic in_window(input logic [STAMP_W-1:0] t,
                                     input logic [WIDTH_W-1:0] lo,
                                     input logic [WIDTH_W-1:0] hi);
    logic upper_zero;
    upper_zero = (t[STAMP_W-1:WIDTH_W] == '0);
    return upper_zero && (t[WIDTH_W-1:0] >= lo) && (t[WIDTH_W-1:0] <= hi);
  endfunction

endpackage

// ===== hw/rtl/rcpw_if.sv =====
// Valid/ready channel interfaces for the RC pulse width capture unit.
// Depends on rcpw_pkg for payload widths.
`timescale 1ns / 1ps

interface rcpw_in_if;
  import rcpw_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [PIN_W-1:0]      pin_levels;
  logic [STAMP_W-1:0]    now_us;
  logic [CHAN_SEL_W-1:0] read_channel;

  modport source (output valid, output pin_levels, output now_us, output read_channel,
                  input ready);
  modport sink   (input valid, input pin_levels, input now_us, input read_channel,
                  output ready);
endinterface

interface rcpw_out_if;
  import rcpw_pkg::*;

  logic               valid;
  logic               ready;
  logic [WIDTH_W-1:0] read_width;
  logic [PIN_W-1:0]   updated_mask;

  modport source (output valid, output read_width, output updated_mask, input ready);
  modport sink   (input valid, input read_width, input updated_mask, output ready);
endinterface

// ===== hw/rtl/rc_pulse_width_capture_unit.sv =====
// RC receiver pulse width capture unit, top level.
// Depends on rcpw_pkg and the channel interfaces in rcpw_if.sv.
//
// Usage:
//   in_item carries one pin sample per item: pin levels, a microsecond
//   timestamp and the channel to read back. out_item returns one result per
//   accepted item: the chosen channel's last good width (after this sample's
//   updates) and a mask of channels whose width was stored by this sample.
//   cfg_write/cfg_index/cfg_data write the enable mask and the four window
//   limits; write them only while no item is in flight.
// Timing:
//   Edge detection, window checks and state update happen in the cycle an
//   item is accepted; its result sits in the output register in the cycle
//   after. One item per cycle is sustained while out_item.ready is high, set
//   by the single result register between the per-channel lanes and out_item.
// Reset and stall:
//   rst clears all stamps, arm flags and previous levels, loads the default
//   widths and window limits, and empties the output register. While out_item
//   holds a result that is not taken, in_item.ready is low and the result holds.
`timescale 1ns / 1ps

module rc_pulse_width_capture_unit #(
  parameter int NUM_CHANNELS = rcpw_pkg::NUM_CHANNELS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  rcpw_in_if.sink                             in_item,
  rcpw_out_if.source                          out_item,
  input  logic                                cfg_write,
  input  logic [rcpw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rcpw_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import rcpw_pkg::*;

  // Configuration registers
  logic [PIN_W-1:0]   channel_enable_mask;
  logic [WIDTH_W-1:0] min_off_width;
  logic [WIDTH_W-1:0] max_off_width;
  logic [WIDTH_W-1:0] min_on_width;
  logic [WIDTH_W-1:0] max_on_width;

  // Per-channel state
  logic [PIN_W-1:0]   previous_levels;
  logic [STAMP_W-1:0] rise_stamp      [NUM_CHANNELS];
  logic [STAMP_W-1:0] fall_stamp      [NUM_CHANNELS];
  logic               armed_flag      [NUM_CHANNELS];
  logic [WIDTH_W-1:0] good_width      [NUM_CHANNELS];
  logic [STAMP_W-1:0] rise_stamp_next [NUM_CHANNELS];
  logic [STAMP_W-1:0] fall_stamp_next [NUM_CHANNELS];
  logic               armed_flag_next [NUM_CHANNELS];
  logic [WIDTH_W-1:0] good_width_next [NUM_CHANNELS];

  // Result register
  logic               out_valid;
  logic [WIDTH_W-1:0] read_width;
  logic [PIN_W-1:0]   updated_mask;
  logic [WIDTH_W-1:0] read_width_next;
  logic [PIN_W-1:0]   updated_mask_next;

  logic               accept;
  logic [PIN_W-1:0]   changed;

  // Take a new item whenever the result register is empty or being drained
  assign in_item.ready = !out_valid || out_item.ready;
  assign accept        = in_item.valid && in_item.ready;

  assign out_item.valid        = out_valid;
  assign out_item.read_width   = read_width;
  assign out_item.updated_mask = updated_mask;

  assign changed = (in_item.pin_levels ^ previous_levels) & channel_enable_mask;

  // Per-channel lanes: handle rises and falls independently
  always_comb begin
    logic [STAMP_W-1:0] off_time;
    logic [STAMP_W-1:0] on_time;
    updated_mask_next = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      off_time           = in_item.now_us - fall_stamp[i];
      on_time            = in_item.now_us - rise_stamp[i];
      rise_stamp_next[i] = rise_stamp[i];
      fall_stamp_next[i] = fall_stamp[i];
      armed_flag_next[i] = armed_flag[i];
      good_width_next[i] = good_width[i];
      if (changed[i]) begin
        if (in_item.pin_levels[i]) begin
          // Rise: arm only after a plausible off time
          rise_stamp_next[i] = in_item.now_us;
          armed_flag_next[i] = in_window(off_time, min_off_width, max_off_width);
        end else begin
          // Fall: store the pulse if armed and in range
          fall_stamp_next[i] = in_item.now_us;
          if (armed_flag[i] && in_window(on_time, min_on_width, max_on_width)) begin
            good_width_next[i]   = on_time[WIDTH_W-1:0];
            armed_flag_next[i]   = 1'b0;
            updated_mask_next[i] = 1'b1;
          end
        end
      end
    end
  end

  // Read back the chosen channel after this sample's updates
  always_comb begin
    read_width_next = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (in_item.read_channel == CHAN_SEL_W'(i)) begin
        read_width_next = good_width_next[i];
      end
    end
  end

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_enable_mask <= ENABLE_RST;
      min_off_width       <= MIN_OFF_RST;
      max_off_width       <= MAX_OFF_RST;
      min_on_width        <= MIN_ON_RST;
      max_on_width        <= MAX_ON_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CHANNEL_ENABLE: channel_enable_mask <= cfg_data[PIN_W-1:0];
        REG_MIN_OFF_WIDTH:  min_off_width       <= cfg_data[WIDTH_W-1:0];
        REG_MAX_OFF_WIDTH:  max_off_width       <= cfg_data[WIDTH_W-1:0];
        REG_MIN_ON_WIDTH:   min_on_width        <= cfg_data[WIDTH_W-1:0];
        REG_MAX_ON_WIDTH:   max_on_width        <= cfg_data[WIDTH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Advance channel state on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_levels <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        rise_stamp[i] <= '0;
        fall_stamp[i] <= '0;
        armed_flag[i] <= 1'b0;
        good_width[i] <= good_width_rst(i);
      end
    end else if (accept) begin
      previous_levels <= in_item.pin_levels;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        rise_stamp[i] <= rise_stamp_next[i];
        fall_stamp[i] <= fall_stamp_next[i];
        armed_flag[i] <= armed_flag_next[i];
        good_width[i] <= good_width_next[i];
      end
    end
  end

  // Result register: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_item.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_width   <= read_width_next;
      updated_mask <= updated_mask_next;
    end
  end

endmodule
